@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// clocked invariant, disabled in reset
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

@@ hdl/mfpc_pkg.sv @@
// types, codes and helper functions for the message frame parser
// no dependencies
package mfpc_pkg;

	localparam int NAME_LIMIT   = 32;
	localparam int OP_LIMIT     = 16;
	localparam int BODY_LIMIT   = 1024;
	localparam int HEADER_LIMIT = 2048;
	localparam int NUM_OPS      = 10;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	localparam logic [1:0] NM_START = 2'd0;
	localparam logic [1:0] NM_DIGIT = 2'd1;
	localparam logic [1:0] NM_STOP  = 2'd2;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_NO_NEWLINE  = 4'd1;
	localparam logic [3:0] ST_HDR_LONG    = 4'd2;
	localparam logic [3:0] ST_DEST_MISS   = 4'd3;
	localparam logic [3:0] ST_DEST_LONG   = 4'd4;
	localparam logic [3:0] ST_ORIG_MISS   = 4'd5;
	localparam logic [3:0] ST_ORIG_LONG   = 4'd6;
	localparam logic [3:0] ST_OP_MISS     = 4'd7;
	localparam logic [3:0] ST_OP_LONG     = 4'd8;
	localparam logic [3:0] ST_OP_UNKNOWN  = 4'd9;
	localparam logic [3:0] ST_LEN_MISS    = 4'd10;
	localparam logic [3:0] ST_LEN_RANGE   = 4'd11;
	localparam logic [3:0] ST_CKS_MISS    = 4'd12;
	localparam logic [3:0] ST_BODY_SHORT  = 4'd13;
	localparam logic [3:0] ST_CKS_BAD     = 4'd14;

	localparam logic [7:0] CH_NL   = 8'd10;
	localparam logic [7:0] CH_BAR  = 8'd124;
	localparam logic [7:0] CH_NUL  = 8'd0;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_MIN  = 8'd45;
	localparam logic [7:0] CH_SP   = 8'd32;

	localparam logic [16:0] MOD_SUM = 17'd65535;

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  op_index;
		logic [10:0] body_length;
		logic [31:0] received_checksum;
		logic [15:0] computed_checksum;
		logic [4:0]  dest_length;
		logic [4:0]  origin_length;
	} result_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [2:0]  token_number;
		logic [5:0]  token_byte_count;
		logic [11:0] header_byte_count;
		logic        header_overflow;
		logic        zero_byte_seen;
		logic [3:0]  first_error;
		logic [9:0]  name_match_mask;
		logic [10:0] length_value;
		logic [31:0] checksum_value;
		logic [15:0] running_sum;
		logic [10:0] body_byte_count;
		logic        in_tok;
		logic        num_neg;
		logic        len_ok;
		logic        cks_present;
		logic [1:0]  num_mode;
		logic [4:0]  dest_len;
		logic [4:0]  orig_len;
		logic [3:0]  op_idx;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_HEADER, token_number: 3'd0, token_byte_count: 6'd0,
		header_byte_count: 12'd0, header_overflow: 1'b0, zero_byte_seen: 1'b0,
		first_error: ST_OK, name_match_mask: 10'h3FF, length_value: 11'd0,
		checksum_value: 32'd0, running_sum: 16'd0, body_byte_count: 11'd0,
		in_tok: 1'b0, num_neg: 1'b0, len_ok: 1'b0, cks_present: 1'b0,
		num_mode: NM_START, dest_len: 5'd0, orig_len: 5'd0, op_idx: 4'd0
	};

	function automatic logic [5:0] op_len(input logic [3:0] i);
		case (i)
			4'd0: op_len = 6'd8;
			4'd1: op_len = 6'd4;
			4'd2: op_len = 6'd6;
			4'd3: op_len = 6'd8;
			4'd4: op_len = 6'd8;
			4'd5: op_len = 6'd9;
			4'd6: op_len = 6'd2;
			4'd7: op_len = 6'd5;
			4'd8: op_len = 6'd8;
			4'd9: op_len = 6'd8;
			default: op_len = 6'd0;
		endcase
	endfunction

	function automatic logic [7:0] op_char(input logic [3:0] i, input logic [3:0] p);
		logic [71:0] s;
		s = '0;
		case (i)
			4'd0: s = {"RETSIGER", 8'd0};
			4'd1: s = {"TIXE", 40'd0};
			4'd2: s = {"SUTATS", 24'd0};
			4'd3: s = {"QER_TSIL", 8'd0};
			4'd4: s = {"SER_TSIL", 8'd0};
			4'd5: s = "TSACDAORB";
			4'd6: s = {"MD", 56'd0};
			4'd7: s = {"RORRE", 32'd0};
			4'd8: s = {"QER_OFNI", 8'd0};
			4'd9: s = {"SER_OFNI", 8'd0};
			default: s = '0;
		endcase
		// chars stored reversed: first char in the lowest used byte
		op_char = 8'd0;
		if (p < op_len(i)) begin
			op_char = s[71 - 8 * (int'(op_len(i)) - 1 - int'(p)) -: 8];
		end
	endfunction

	function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [10:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {6'd0, b};
		if (t >= MOD_SUM) begin
			t = t - MOD_SUM;
		end
		add_mod = t[15:0];
	endfunction

endpackage

@@ hdl/mfpc_parse.sv @@
// per-byte parse state and summary result logic
// depends on mfpc_pkg
module mfpc_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output mfpc_pkg::result_t res,
	output logic              res_valid
);
	import mfpc_pkg::*;

	parse_state_t st_q;
	parse_state_t nx;

	function automatic parse_state_t set_err(input parse_state_t s, input logic [3:0] e);
		parse_state_t r;
		r = s;
		if (r.first_error == ST_OK) begin
			r.first_error = e;
		end
		return r;
	endfunction

	function automatic parse_state_t end_tok(input parse_state_t s);
		parse_state_t r;
		logic [2:0]   k;
		logic [4:0]   sat;
		logic         hit;
		r = s;
		k = s.token_number - 3'd1;
		sat = (s.token_byte_count > 6'd31) ? 5'd31 : s.token_byte_count[4:0];
		hit = 1'b0;
		r.in_tok = 1'b0;
		case (k)
			3'd0: begin
				r.dest_len = sat;
				if (s.token_byte_count >= 6'(NAME_LIMIT)) r = set_err(r, ST_DEST_LONG);
			end
			3'd1: begin
				r.orig_len = sat;
				if (s.token_byte_count >= 6'(NAME_LIMIT)) r = set_err(r, ST_ORIG_LONG);
			end
			3'd2: begin
				if (s.token_byte_count >= 6'(OP_LIMIT)) begin
					r = set_err(r, ST_OP_LONG);
				end else begin
					for (int i = NUM_OPS - 1; i >= 0; i--) begin
						if (s.name_match_mask[i] && s.token_byte_count == op_len(4'(i))) begin
							hit = 1'b1;
							r.op_idx = 4'(i);
						end
					end
					if (!hit) r = set_err(r, ST_OP_UNKNOWN);
				end
			end
			3'd3: begin
				if ((s.num_neg && s.length_value != 11'd0) ||
				    s.length_value > 11'(BODY_LIMIT)) begin
					r = set_err(r, ST_LEN_RANGE);
				end else begin
					r.len_ok = 1'b1;
					r.running_sum = add_mod(s.running_sum, s.length_value);
				end
			end
			3'd4: begin
				r.cks_present = 1'b1;
				if (s.num_neg && s.checksum_value != 32'hFFFF_FFFF) begin
					r.checksum_value = 32'd0 - s.checksum_value;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic parse_state_t feed_num(input parse_state_t s, input logic [7:0] b,
		input logic is_len);
		parse_state_t r;
		logic         dig;
		logic [3:0]   d;
		logic [14:0]  lv;
		logic [35:0]  cv;
		r = s;
		dig = (b >= 8'd48) && (b <= 8'd57);
		d = 4'(b - 8'd48);
		lv = ({4'd0, s.length_value} << 3) + ({4'd0, s.length_value} << 1) + {11'd0, d};
		cv = ({4'd0, s.checksum_value} << 3) + ({4'd0, s.checksum_value} << 1) + {32'd0, d};
		if (s.num_mode == NM_START && (b == CH_SP || (b >= 8'd9 && b <= 8'd13))) begin
		end else if (s.num_mode == NM_START && b == CH_PLUS) begin
			r.num_mode = NM_DIGIT;
		end else if (s.num_mode == NM_START && b == CH_MIN) begin
			r.num_mode = NM_DIGIT;
			r.num_neg = 1'b1;
		end else if (s.num_mode == NM_STOP) begin
		end else if (!dig) begin
			r.num_mode = NM_STOP;
		end else begin
			r.num_mode = NM_DIGIT;
			if (is_len) begin
				r.length_value = (lv > 15'(BODY_LIMIT)) ? 11'(BODY_LIMIT + 1) : lv[10:0];
			end else begin
				r.checksum_value = (cv[35:32] != 4'd0) ? 32'hFFFF_FFFF : cv[31:0];
			end
		end
		return r;
	endfunction

	function automatic parse_state_t feed_tok(input parse_state_t s, input logic [7:0] b);
		parse_state_t r;
		logic [2:0]   k;
		logic [5:0]   p;
		r = s;
		k = s.token_number - 3'd1;
		p = s.token_byte_count;
		if (s.token_byte_count != 6'h3F) r.token_byte_count = s.token_byte_count + 6'd1;
		if (k <= 3'd2) r.running_sum = add_mod(s.running_sum, {3'd0, b});
		case (k)
			3'd2: begin
				for (int i = 0; i < NUM_OPS; i++) begin
					if (p >= op_len(4'(i)) || op_char(4'(i), p[3:0]) != b) begin
						r.name_match_mask[i] = 1'b0;
					end
				end
			end
			3'd3: r = feed_num(r, b, 1'b1);
			3'd4: r = feed_num(r, b, 1'b0);
			default: ;
		endcase
		return r;
	endfunction

	always_comb begin
		logic [3:0] stat;
		logic       emit;
		nx = st_q;
		stat = ST_OK;
		emit = 1'b0;
		if (st_q.phase == PH_HEADER) begin
			if (data_byte == CH_NL) begin
				if (nx.in_tok) nx = end_tok(nx);
				if (nx.token_number < 3'd1) nx = set_err(nx, ST_DEST_MISS);
				else if (nx.token_number < 3'd2) nx = set_err(nx, ST_ORIG_MISS);
				else if (nx.token_number < 3'd3) nx = set_err(nx, ST_OP_MISS);
				else if (nx.token_number < 3'd4) nx = set_err(nx, ST_LEN_MISS);
				else if (nx.token_number < 3'd5) nx = set_err(nx, ST_CKS_MISS);
				if (nx.header_overflow) begin
					emit = 1'b1;
					stat = ST_HDR_LONG;
					nx.phase = PH_SKIP;
				end else if (nx.first_error != ST_OK) begin
					emit = 1'b1;
					stat = nx.first_error;
					nx.phase = PH_SKIP;
				end else begin
					nx.phase = PH_BODY;
					nx.body_byte_count = 11'd0;
					if (nx.length_value == 11'd0) begin
						emit = 1'b1;
						stat = ({16'd0, nx.running_sum} == nx.checksum_value) ? ST_OK : ST_CKS_BAD;
						nx.phase = PH_SKIP;
					end
				end
			end else begin
				if (!nx.header_overflow) begin
					nx.header_byte_count = nx.header_byte_count + 12'd1;
					if (nx.header_byte_count >= 12'(HEADER_LIMIT)) nx.header_overflow = 1'b1;
				end
				if (!nx.zero_byte_seen) begin
					if (data_byte == CH_NUL) begin
						if (nx.in_tok) nx = end_tok(nx);
						nx.zero_byte_seen = 1'b1;
					end else if (data_byte == CH_BAR) begin
						if (nx.in_tok) nx = end_tok(nx);
					end else begin
						if (!nx.in_tok && nx.token_number < 3'd5) begin
							nx.in_tok = 1'b1;
							nx.token_number = nx.token_number + 3'd1;
							nx.token_byte_count = 6'd0;
							nx.name_match_mask = 10'h3FF;
							nx.num_mode = NM_START;
							nx.num_neg = 1'b0;
						end
						if (nx.in_tok) nx = feed_tok(nx, data_byte);
					end
				end
			end
		end else if (st_q.phase == PH_BODY) begin
			nx.running_sum = add_mod(nx.running_sum, {3'd0, data_byte});
			nx.body_byte_count = nx.body_byte_count + 11'd1;
			if (nx.body_byte_count >= nx.length_value) begin
				emit = 1'b1;
				stat = ({16'd0, nx.running_sum} == nx.checksum_value) ? ST_OK : ST_CKS_BAD;
				nx.phase = PH_SKIP;
			end
		end
		if (final_byte && !emit) begin
			if (nx.phase == PH_HEADER) begin
				emit = 1'b1;
				stat = ST_NO_NEWLINE;
			end else if (nx.phase == PH_BODY) begin
				emit = 1'b1;
				stat = ST_BODY_SHORT;
			end
		end
		res_valid = emit;
		res.status = stat;
		if (stat == ST_NO_NEWLINE || stat == ST_HDR_LONG) begin
			res.op_index = 4'd0;
			res.body_length = 11'd0;
			res.received_checksum = 32'd0;
			res.dest_length = 5'd0;
			res.origin_length = 5'd0;
		end else begin
			res.op_index = nx.op_idx;
			res.body_length = nx.len_ok ? nx.length_value : 11'd0;
			res.received_checksum = nx.cks_present ? nx.checksum_value : 32'd0;
			res.dest_length = nx.dest_len;
			res.origin_length = nx.orig_len;
		end
		res.computed_checksum = (stat == ST_OK || stat == ST_CKS_BAD) ? nx.running_sum : 16'd0;
		if (final_byte) nx = STATE_RESET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (en) begin
			st_q <= nx;
		end
	end

endmodule

@@ hdl/message_frame_parse_check_core.sv @@
// path: a byte is held in the input register when accepted and parsed when the result
// register can advance; a result word it causes is registered there for the master side
// throughput: one byte a cycle while the master side takes words; a result word waiting
// there stalls the slave side, once the input register holds a byte, until it is taken
// reset: arst_n clears the parse state to header phase and drops both valids
// top level: input register, parser and result register; uses mfpc_pkg, mfpc_parse
`include "assert_macros.svh"
module message_frame_parse_check_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // status, op_index, body_length, received_checksum,
	                               // computed_checksum, dest_length, origin_length, zero pad
);
	import mfpc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic       go;
	result_t    res;
	logic       res_valid;
	result_t    res_q;
	logic       out_valid_q;
	logic [3:0] out_status;
	logic       hdr_word;
	logic       sum_word;

	assign adv = !out_valid_q || m_tready;
	assign go = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mfpc_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (go),
		.data_byte  (byte_s1),
		.final_byte (last_s1),
		.res        (res),
		.res_valid  (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= go && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'd0, res_q.origin_length, res_q.dest_length, res_q.computed_checksum,
		res_q.received_checksum, res_q.body_length, res_q.op_index, res_q.status};

	assign out_status = m_tdata[3:0];
	assign hdr_word = m_tvalid && (out_status == ST_NO_NEWLINE || out_status == ST_HDR_LONG);
	assign sum_word = m_tvalid && m_tdata[66:51] != 16'd0;

	`CHK_IMPL(a_stall_src, clk, arst_n, !s_tready, m_tvalid && !m_tready, "stall without backpressure")
	`CHK_IMPL(a_hdr_zero, clk, arst_n, hdr_word, m_tdata[76:4] == 73'd0, "header error word carries data")
	`CHK_IMPL(a_cks_status, clk, arst_n, sum_word, out_status == ST_OK || out_status == ST_CKS_BAD, "sum on wrong status")
	`CHK_IMPL(a_status_range, clk, arst_n, m_tvalid, out_status != 4'd15, "status out of range")

endmodule
